### hw/rtl/spxl_pkg.sv
// Shared types and constants for the sub-pixel image translation block.
package spxl_pkg;

    localparam int MAX_ROWS  = 512;
    localparam int MAX_COLS  = 512;
    localparam int FRAC_BITS = 8;

    localparam int ROW_BITS  = $clog2(MAX_ROWS);
    localparam int COL_BITS  = $clog2(MAX_COLS);
    localparam int ADDR_BITS = ROW_BITS + COL_BITS;
    localparam int MEM_DEPTH = 1 << ADDR_BITS;

    localparam int ROW_W     = 9;
    localparam int COL_W     = 9;
    localparam int PIXEL_W   = 8;
    localparam int VALUE_W   = 16;
    localparam int SHIFT_X_W = 18;
    localparam int SHIFT_Y_W = 10;
    localparam int DIM_W     = 10;
    localparam int ITX_W     = SHIFT_X_W - FRAC_BITS;
    localparam int POS_W     = 20;
    localparam int WGT_W     = FRAC_BITS + 1;
    localparam int PROD_W    = WGT_W + PIXEL_W;

    localparam int PADDR_W   = 4;
    localparam int PDATA_W   = 32;

    localparam logic [1:0] REG_SHIFT_X     = 2'd0;
    localparam logic [1:0] REG_SHIFT_Y     = 2'd1;
    localparam logic [1:0] REG_ROWS_IN_USE = 2'd2;
    localparam logic [1:0] REG_COLS_IN_USE = 2'd3;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_READ  = 1'b1;

    typedef struct packed {
        logic signed [SHIFT_X_W-1:0] shift_x;
        logic signed [SHIFT_Y_W-1:0] shift_y;
        logic [DIM_W-1:0]            rows_in_use;
        logic [DIM_W-1:0]            cols_in_use;
    } cfg_t;

    typedef struct packed {
        logic write_en;
        logic capture;
        logic read_second;
        logic multiply;
        logic load_out;
    } dp_cmd_t;

endpackage

### hw/rtl/subpixel_image_translation_top.sv
// Top level of the sub-pixel image translation block.
//
// The input channel (in_valid, in_stall, command, row, col, pixel) carries one
// transfer per command. A write command stores one 8-bit source pixel into the
// frame store; it produces no result. A read command
// returns one pixel of the translated image on the output channel (out_valid,
// out_stall, value) as an unsigned 8.8 intensity, blended from two horizontally
// adjacent source pixels.
// A read occupies the block through the states READ_A, READ_B, MULT and OUT:
// the single read port of the frame store fetches the two source pixels in
// successive cycles, then a multiply stage and an output load follow, after
// which the controller returns to idle and can take the next command.
// The result sits in an output register, so a new command may be accepted while
// it waits; a further read then holds in its final stage until the receiver
// takes the pending result. Shifts and frame size are set through the APB-style
// port while the block is idle, which the user, not the block, must ensure.
// Reset clears the handshake state and the registers to no shift and a full
// 512 by 512 frame; the frame store contents are undefined until written.
module subpixel_image_translation_top (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic                         command,
    input  logic [spxl_pkg::ROW_W-1:0]   row,
    input  logic [spxl_pkg::COL_W-1:0]   col,
    input  logic [spxl_pkg::PIXEL_W-1:0] pixel,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [spxl_pkg::VALUE_W-1:0] value,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [spxl_pkg::PADDR_W-1:0] paddr,
    input  logic [spxl_pkg::PDATA_W-1:0] pwdata,
    output logic [spxl_pkg::PDATA_W-1:0] prdata,
    output logic                         pready
);
    import spxl_pkg::*;

    cfg_t    cfg;
    dp_cmd_t dp_cmd;

    assign pready = 1'b1;

    spxl_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg)
    );

    spxl_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .command   (command),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .dp_cmd    (dp_cmd)
    );

    spxl_dp u_dp (
        .clk   (clk),
        .cfg   (cfg),
        .cmd   (dp_cmd),
        .row   (row),
        .col   (col),
        .pixel (pixel),
        .value (value)
    );

endmodule

### hw/rtl/spxl_cfg.sv
// Configuration register file with its APB-style access port.
module spxl_cfg (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [spxl_pkg::PADDR_W-1:0] paddr,
    input  logic [spxl_pkg::PDATA_W-1:0] pwdata,
    output logic [spxl_pkg::PDATA_W-1:0] prdata,
    output spxl_pkg::cfg_t               cfg
);
    import spxl_pkg::*;

    cfg_t       cfg_reg;
    cfg_t       cfg_next;
    logic [1:0] reg_index;
    logic       wr_strobe;

    assign reg_index = paddr[3:2];
    assign wr_strobe = psel && penable && pwrite;
    assign cfg       = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_strobe)
        begin
            case (reg_index)
                REG_SHIFT_X:     cfg_next.shift_x     = pwdata[SHIFT_X_W-1:0];
                REG_SHIFT_Y:     cfg_next.shift_y     = pwdata[SHIFT_Y_W-1:0];
                REG_ROWS_IN_USE: cfg_next.rows_in_use = pwdata[DIM_W-1:0];
                REG_COLS_IN_USE: cfg_next.cols_in_use = pwdata[DIM_W-1:0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.shift_x     <= '0;
            cfg_reg.shift_y     <= '0;
            cfg_reg.rows_in_use <= DIM_W'(MAX_ROWS);
            cfg_reg.cols_in_use <= DIM_W'(MAX_COLS);
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb
    begin
        case (reg_index)
            REG_SHIFT_X:     prdata = PDATA_W'(cfg_reg.shift_x);
            REG_SHIFT_Y:     prdata = PDATA_W'(cfg_reg.shift_y);
            REG_ROWS_IN_USE: prdata = PDATA_W'(cfg_reg.rows_in_use);
            REG_COLS_IN_USE: prdata = PDATA_W'(cfg_reg.cols_in_use);
            default:         prdata = '0;
        endcase
    end

endmodule

### hw/rtl/spxl_dp.sv
// Datapath: frame store, source address generation, interpolation and output register.
module spxl_dp (
    input  logic                         clk,
    input  spxl_pkg::cfg_t               cfg,
    input  spxl_pkg::dp_cmd_t            cmd,
    input  logic [spxl_pkg::ROW_W-1:0]   row,
    input  logic [spxl_pkg::COL_W-1:0]   col,
    input  logic [spxl_pkg::PIXEL_W-1:0] pixel,
    output logic [spxl_pkg::VALUE_W-1:0] value
);
    import spxl_pkg::*;

    logic [PIXEL_W-1:0]   mem [0:MEM_DEPTH-1];

    logic [ROW_W-1:0]     row_reg;
    logic [COL_W-1:0]     col_reg;
    logic [PIXEL_W-1:0]   rd_data_reg;
    logic                 valid1_reg;
    logic                 valid2_reg;
    logic                 in_frame_reg;
    logic [PIXEL_W-1:0]   s1_reg;
    logic [PROD_W-1:0]    p1_reg;
    logic [PROD_W-1:0]    p2_reg;
    logic [VALUE_W-1:0]   value_reg;

    logic                 neg;
    logic [SHIFT_X_W-1:0] mag;
    logic [FRAC_BITS-1:0] frac;
    logic [ITX_W-1:0]     itx_mag;
    logic [WGT_W-1:0]     w1;
    logic [WGT_W-1:0]     w2;
    logic [POS_W-1:0]     eff_rows;
    logic [POS_W-1:0]     eff_cols;
    logic [POS_W-1:0]     rows_ext;
    logic [POS_W-1:0]     cols_ext;
    logic [POS_W-1:0]     row_ext;
    logic [POS_W-1:0]     col_ext;
    logic [POS_W-1:0]     itx_ext;
    logic [POS_W-1:0]     r_pos;
    logic [POS_W-1:0]     c_pos;
    logic [POS_W-1:0]     c2_pos;
    logic                 r_ok;
    logic                 valid1;
    logic                 valid2;
    logic                 in_frame;
    logic [ADDR_BITS-1:0] addr_a;
    logic [ADDR_BITS-1:0] addr_b;
    logic [ADDR_BITS-1:0] raddr;
    logic [ADDR_BITS-1:0] waddr;
    logic                 wr_in_range;
    logic [PIXEL_W-1:0]   s2;

    assign neg     = cfg.shift_x[SHIFT_X_W-1];
    assign mag     = neg ? SHIFT_X_W'(-cfg.shift_x) : SHIFT_X_W'(cfg.shift_x);
    assign frac    = mag[FRAC_BITS-1:0];
    assign itx_mag = mag[SHIFT_X_W-1:FRAC_BITS];
    assign w2      = WGT_W'(frac);
    assign w1      = (WGT_W'(1) << FRAC_BITS) - w2;

    assign rows_ext = POS_W'(cfg.rows_in_use);
    assign cols_ext = POS_W'(cfg.cols_in_use);
    assign eff_rows = (rows_ext > POS_W'(MAX_ROWS)) ? POS_W'(MAX_ROWS) : rows_ext;
    assign eff_cols = (cols_ext > POS_W'(MAX_COLS)) ? POS_W'(MAX_COLS) : cols_ext;

    assign row_ext = POS_W'(row_reg);
    assign col_ext = POS_W'(col_reg);
    assign itx_ext = POS_W'(itx_mag);
    assign r_pos   = row_ext - POS_W'(cfg.shift_y);
    assign c_pos   = neg ? (col_ext + itx_ext) : (col_ext - itx_ext);
    assign c2_pos  = neg ? (c_pos + POS_W'(1)) : (c_pos - POS_W'(1));

    assign r_ok     = !r_pos[POS_W-1] && (r_pos < eff_rows);
    assign valid1   = r_ok && !c_pos[POS_W-1] && (c_pos < eff_cols);
    assign valid2   = r_ok && !c2_pos[POS_W-1] && (c2_pos < eff_cols);
    assign in_frame = (row_ext < eff_rows) && (col_ext < eff_cols);

    assign addr_a = {r_pos[ROW_BITS-1:0], c_pos[COL_BITS-1:0]};
    assign addr_b = {r_pos[ROW_BITS-1:0], c2_pos[COL_BITS-1:0]};
    assign raddr  = cmd.read_second ? addr_b : addr_a;

    assign waddr       = {ROW_BITS'(row), COL_BITS'(col)};
    assign wr_in_range = (POS_W'(row) < POS_W'(MAX_ROWS)) && (POS_W'(col) < POS_W'(MAX_COLS));

    assign s2 = valid2_reg ? rd_data_reg : '0;

    always_ff @(posedge clk)
    begin
        if (cmd.write_en && wr_in_range)
        begin
            mem[waddr] <= pixel;
        end
        rd_data_reg <= mem[raddr];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            row_reg <= row;
            col_reg <= col;
        end
        valid1_reg   <= valid1;
        in_frame_reg <= in_frame;
        if (cmd.read_second)
        begin
            s1_reg     <= valid1_reg ? rd_data_reg : '0;
            valid2_reg <= valid2;
        end
        if (cmd.multiply)
        begin
            p1_reg <= PROD_W'(w1) * PROD_W'(s1_reg);
            p2_reg <= PROD_W'(w2) * PROD_W'(s2);
        end
        if (cmd.load_out)
        begin
            value_reg <= in_frame_reg ? VALUE_W'(p1_reg + p2_reg) : '0;
        end
    end

    assign value = value_reg;

endmodule

### hw/rtl/spxl_ctrl.sv
// Controller: handshakes and the sequence of a read transfer.
module spxl_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic                 command,
    output logic                 out_valid,
    input  logic                 out_stall,
    output spxl_pkg::dp_cmd_t    dp_cmd
);
    import spxl_pkg::*;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_READ_A = 3'd1;
    localparam logic [2:0] ST_READ_B = 3'd2;
    localparam logic [2:0] ST_MULT   = 3'd3;
    localparam logic [2:0] ST_OUT    = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       accept;
    logic       load;

    assign in_stall = (state_reg != ST_IDLE);
    assign accept   = in_valid && !in_stall;
    assign load     = (state_reg == ST_OUT) && (!out_valid_reg || !out_stall);

    assign dp_cmd.write_en    = accept && (command == CMD_WRITE);
    assign dp_cmd.capture     = accept && (command == CMD_READ);
    assign dp_cmd.read_second = (state_reg == ST_READ_B);
    assign dp_cmd.multiply    = (state_reg == ST_MULT);
    assign dp_cmd.load_out    = load;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && (command == CMD_READ))
                begin
                    state_next = ST_READ_A;
                end
            end
            ST_READ_A: state_next = ST_READ_B;
            ST_READ_B: state_next = ST_MULT;
            ST_MULT:   state_next = ST_OUT;
            ST_OUT:
            begin
                if (load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        if (load)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule
